FILE: sv/gtpg_pkg.sv
package gtpg_pkg;

  // Default sizing of the tour store and the coordinate width.
  localparam int unsigned MaxPointsDef  = 4096;
  localparam int unsigned CoordWidthDef = 16;

  // Configuration register index.
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] REG_X_LOW  = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_X_HIGH = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_Y_LOW  = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_Y_HIGH = 4'd3;

  // Result status codes.
  localparam int unsigned StatusW = 2;
  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [StatusW-1:0] STATUS_OVERSIZE = 2'd2;

endpackage

FILE: sv/gtpg_if.sv
// Request channel: one transaction asks for the next tour point.
interface gtpg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// Point channel: one transaction carries one tour point.
interface gtpg_pt_if #(
  parameter int unsigned CW = gtpg_pkg::CoordWidthDef
);
  logic                          valid;
  logic                          ready;
  logic [CW-1:0]                 point_x;
  logic [CW-1:0]                 point_y;
  logic                          last_point;
  logic [gtpg_pkg::StatusW-1:0]  status;
  logic                          vertical_raster;

  modport source (output valid, output point_x, output point_y, output last_point,
                  output status, output vertical_raster, input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  input status, input vertical_raster, output ready);
endinterface

// Configuration write channel.
interface gtpg_cfg_if #(
  parameter int unsigned CW = gtpg_pkg::CoordWidthDef
);
  logic                          valid;
  logic                          ready;
  logic [gtpg_pkg::CfgIdxW-1:0]  index;
  logic [CW-1:0]                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/grid_tour_point_generator.sv
// Channel   Direction  Contents
// cfg_i     in         index, data            (grid bounds x_low..y_high)
// req_i     in         restart
// pt_o      out        point_x, point_y, last_point, status, vertical_raster
//
// A request on an active tour presents its point through ST_LOAD and the output
// register; the tour store read is already under way at its registered read port.
// A request that builds a tour writes it into the store at one point per cycle
// within a segment; each new segment is loaded in a step with no write.
// Reset clears the bounds, the orientation history and the active tour.
// One request is in work at a time; the request channel waits while a point
// is held on the output.
module grid_tour_point_generator #(
  parameter int unsigned MAX_POINTS  = gtpg_pkg::MaxPointsDef,
  parameter int unsigned COORD_WIDTH = gtpg_pkg::CoordWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtpg_cfg_if.sink    cfg_i,
  gtpg_req_if.sink    req_i,
  gtpg_pt_if.source   pt_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned FW    = $clog2(MAX_POINTS + 2);
  localparam int unsigned AW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned CNW   = FW + 1;
  localparam int unsigned NW    = CW + 1;
  localparam int unsigned EW    = CW + 2;
  localparam int unsigned PW    = 2 * NW;
  localparam int unsigned DEPTH = MAX_POINTS + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIZE, ST_MUL, ST_DECIDE, ST_GEN, ST_FIN, ST_W1, ST_W2, ST_LOAD
  } state_e;

  typedef enum logic [3:0] {
    SG_START, SG_LA, SG_LB, SG_LC, SG_E1, SG_E2, SG_E3,
    SG_O1, SG_O2, SG_O3, SG_O4, SG_O5, SG_O6, SG_DONE
  } seg_e;

  // Bound registers.
  logic signed [CW-1:0] xl_q, xh_q, yl_q, yh_q;

  state_e             state_q;
  seg_e               seg_q, first_q, nxt_seg;
  logic               last_dir_q, tour_vert_q, active_q, swap_q, is2d_q, near_q;
  logic               empty_q;
  logic [NW-1:0]      nx_q, ny_q;
  logic [PW-1:0]      prod_q;
  logic [CW-1:0]      ax_q, ay_q;
  logic [FW-1:0]      rows_q, cols_q, n_q, a_q;
  logic [FW-1:0]      r_q, c_q, rows_left_q;
  logic               dir_q;
  logic [CNW-1:0]     cnt_q;
  logic [FW-1:0]      fill_q, k_q, mod_q, len_q, pos_q;
  logic [AW-1:0]      rd_addr_q;
  logic [2*CW-1:0]    rdata_q;
  logic [2*CW-1:0]    mem_q [DEPTH];

  logic               out_valid_q, out_last_q, out_vert_q;
  logic [CW-1:0]      out_x_q, out_y_q;
  logic [gtpg_pkg::StatusW-1:0] out_status_q;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xl_q <= '0;
      xh_q <= '0;
      yl_q <= '0;
      yh_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gtpg_pkg::REG_X_LOW:  xl_q <= cfg_i.data;
        gtpg_pkg::REG_X_HIGH: xh_q <= cfg_i.data;
        gtpg_pkg::REG_Y_LOW:  yl_q <= cfg_i.data;
        gtpg_pkg::REG_Y_HIGH: yh_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Axis sizes and anchor.
  logic [EW-1:0] dx_c, dy_c;
  logic [CW-1:0] ax_c, ay_c;
  assign dx_c = {{2{xh_q[CW-1]}}, xh_q} - {{2{xl_q[CW-1]}}, xl_q} + EW'(1);
  assign dy_c = {{2{yh_q[CW-1]}}, yh_q} - {{2{yl_q[CW-1]}}, yl_q} + EW'(1);
  assign ax_c = (xl_q > 0) ? xl_q : ((xh_q < 0) ? xh_q : '0);
  assign ay_c = (yl_q > 0) ? yl_q : ((yh_q < 0) ? yh_q : '0);

  // Shape decision from the registered sizes.
  logic          line_c, vert_c, swap_c, oversize_c;
  logic [FW-1:0] n_c, a_c, rows_c, cols_c;
  always_comb begin
    line_c     = (nx_q == NW'(1)) || (ny_q == NW'(1));
    oversize_c = (PW'(nx_q) > PW'(MAX_POINTS)) || (PW'(ny_q) > PW'(MAX_POINTS)) ||
                 (prod_q > PW'(MAX_POINTS));
    vert_c     = (nx_q[0] == ny_q[0]) ? !last_dir_q : !nx_q[0];
    swap_c     = line_c ? (ny_q != NW'(1)) : vert_c;
    n_c        = swap_c ? FW'(ny_q) : FW'(nx_q);
    a_c        = swap_c ? FW'(ay_q - yl_q) : FW'(ax_q - xl_q);
    rows_c     = vert_c ? FW'(nx_q) : FW'(ny_q);
    cols_c     = vert_c ? FW'(ny_q) : FW'(nx_q);
  end

  // Segment order of the tour.
  always_comb begin
    case (seg_q)
      SG_START: nxt_seg = first_q;
      SG_LA:    nxt_seg = SG_LB;
      SG_LB:    nxt_seg = SG_LC;
      SG_E1:    nxt_seg = SG_E2;
      SG_E2:    nxt_seg = SG_E3;
      SG_O1:    nxt_seg = SG_O2;
      SG_O2:    nxt_seg = SG_O3;
      SG_O3:    nxt_seg = SG_O4;
      SG_O4:    nxt_seg = SG_O5;
      SG_O5:    nxt_seg = SG_O6;
      default:  nxt_seg = SG_DONE;
    endcase
  end

  // Start values of the next segment.
  logic [FW-1:0]  ld_r, ld_c, ld_rows;
  logic [CNW-1:0] ld_cnt;
  logic           ld_dir;
  always_comb begin
    ld_r    = '0;
    ld_c    = '0;
    ld_rows = '0;
    ld_cnt  = '0;
    ld_dir  = 1'b1;
    case (nxt_seg)
      SG_LA: begin
        ld_c   = a_q;
        ld_cnt = near_q ? CNW'(a_q) + CNW'(1) : CNW'(n_q - a_q);
      end
      SG_LB: begin
        ld_c   = near_q ? a_q + FW'(1) : a_q - FW'(1);
        ld_cnt = near_q ? CNW'(n_q - a_q - FW'(1)) : CNW'(a_q);
      end
      SG_LC: begin
        ld_c   = a_q;
        ld_cnt = CNW'(1);
      end
      SG_E1, SG_O1: ld_cnt = CNW'(rows_q);
      SG_E2: begin
        ld_r    = rows_q - FW'(1);
        ld_c    = FW'(1);
        ld_rows = rows_q - FW'(1);
        ld_cnt  = CNW'(cols_q - FW'(1));
      end
      SG_E3: begin
        ld_c   = cols_q - FW'(1);
        ld_cnt = CNW'(cols_q - FW'(1));
      end
      SG_O2: begin
        ld_r   = rows_q - FW'(1);
        ld_c   = FW'(1);
        ld_cnt = CNW'(cols_q - FW'(1));
      end
      SG_O3: begin
        ld_r    = rows_q - FW'(2);
        ld_c    = cols_q - FW'(1);
        ld_dir  = 1'b0;
        ld_rows = rows_q - FW'(3);
        ld_cnt  = (rows_q == FW'(3)) ? '0 : CNW'(cols_q - FW'(1));
      end
      SG_O4: ld_cnt = CNW'(3);
      SG_O5: begin
        ld_c   = cols_q - FW'(2);
        ld_cnt = CNW'(cols_q - FW'(3)) << 1;
      end
      SG_O6: begin
        ld_c   = FW'(1);
        ld_cnt = CNW'(1);
      end
      default: ;
    endcase
  end

  // Point of the current step and the walk to the following one.
  logic [FW-1:0]  pr, pc, r_d, c_d, rows_left_d;
  logic [CNW-1:0] cnt_d;
  logic           dir_d;
  always_comb begin
    pr          = r_q;
    pc          = c_q;
    r_d         = r_q;
    c_d         = c_q;
    rows_left_d = rows_left_q;
    dir_d       = dir_q;
    cnt_d       = cnt_q - CNW'(1);
    case (seg_q)
      SG_LA: c_d = near_q ? c_q - FW'(1) : c_q + FW'(1);
      SG_LB: c_d = near_q ? c_q + FW'(1) : c_q - FW'(1);
      SG_E1, SG_O1: r_d = r_q + FW'(1);
      SG_E3: c_d = c_q - FW'(1);
      SG_O2: c_d = c_q + FW'(1);
      SG_E2, SG_O3: begin
        if (cnt_q == CNW'(1) && rows_left_q > FW'(1)) begin
          r_d         = r_q - FW'(1);
          dir_d       = !dir_q;
          c_d         = dir_q ? cols_q - FW'(1) : FW'(1);
          cnt_d       = CNW'(cols_q - FW'(1));
          rows_left_d = rows_left_q - FW'(1);
        end else begin
          c_d = dir_q ? c_q + FW'(1) : c_q - FW'(1);
        end
      end
      SG_O4: begin
        pr = (cnt_q == CNW'(1)) ? '0 : FW'(1);
        pc = (cnt_q == CNW'(2)) ? cols_q - FW'(2) : cols_q - FW'(1);
      end
      SG_O5: begin
        case (cnt_q[1:0])
          2'b00:   begin pr = '0;     pc = c_q;          end
          2'b11:   begin pr = '0;     pc = c_q - FW'(1); end
          2'b10:   begin pr = FW'(1); pc = c_q - FW'(1); end
          default: begin pr = FW'(1); pc = c_q - FW'(2); end
        endcase
        if (cnt_q[1:0] == 2'b01) c_d = c_q - FW'(2);
      end
      default: ;
    endcase
  end

  logic [CW-1:0] px_c, py_c;
  logic          we_c;
  assign px_c = xl_q + CW'(swap_q ? pr : pc);
  assign py_c = yl_q + CW'(swap_q ? pc : pr);
  assign we_c = (state_q == ST_GEN) && (cnt_q != '0);

  // Rotation: read position p maps to store entry (k + p) mod the number of stored points.
  logic [FW:0] sum_c, addr_c;
  logic        last_c;
  assign sum_c  = {1'b0, k_q} + {1'b0, pos_q};
  assign addr_c = (sum_c >= {1'b0, mod_q}) ? sum_c - {1'b0, mod_q} : sum_c;
  assign last_c = ({1'b0, pos_q} + (FW+1)'(1)) >= {1'b0, len_q};

  // Tour store.
  always_ff @(posedge clk_i) begin
    if (we_c) mem_q[fill_q[AW-1:0]] <= {px_c, py_c};
    rdata_q   <= mem_q[rd_addr_q];
    rd_addr_q <= addr_c[AW-1:0];
  end

  // Control sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seg_q        <= SG_START;
      first_q      <= SG_LC;
      last_dir_q   <= 1'b0;
      tour_vert_q  <= 1'b0;
      active_q     <= 1'b0;
      swap_q       <= 1'b0;
      is2d_q       <= 1'b0;
      near_q       <= 1'b0;
      empty_q      <= 1'b0;
      nx_q         <= '0;
      ny_q         <= '0;
      prod_q       <= '0;
      ax_q         <= '0;
      ay_q         <= '0;
      rows_q       <= '0;
      cols_q       <= '0;
      n_q          <= '0;
      a_q          <= '0;
      r_q          <= '0;
      c_q          <= '0;
      rows_left_q  <= '0;
      dir_q        <= 1'b1;
      cnt_q        <= '0;
      fill_q       <= '0;
      k_q          <= '0;
      mod_q        <= '0;
      len_q        <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= gtpg_pkg::STATUS_OK;
      out_vert_q   <= 1'b0;
    end else begin
      if (out_valid_q && pt_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid && !out_valid_q) begin
            if (req_i.restart || !active_q) begin
              active_q <= 1'b0;
              state_q  <= ST_SIZE;
            end else begin
              state_q <= ST_LOAD;
            end
          end
        end
        ST_SIZE: begin
          empty_q <= (xh_q < xl_q) || (yh_q < yl_q);
          nx_q    <= dx_c[NW-1:0];
          ny_q    <= dy_c[NW-1:0];
          ax_q    <= ax_c;
          ay_q    <= ay_c;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= PW'(nx_q) * PW'(ny_q);
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (empty_q || oversize_c) begin
            out_valid_q  <= 1'b1;
            out_x_q      <= '0;
            out_y_q      <= '0;
            out_last_q   <= 1'b1;
            out_status_q <= empty_q ? gtpg_pkg::STATUS_EMPTY : gtpg_pkg::STATUS_OVERSIZE;
            out_vert_q   <= 1'b0;
            state_q      <= ST_IDLE;
          end else begin
            swap_q      <= swap_c;
            tour_vert_q <= swap_c;
            is2d_q      <= !line_c;
            n_q         <= n_c;
            a_q         <= a_c;
            near_q      <= ({1'b0, a_c} + {1'b0, a_c}) <= ({1'b0, n_c} - (FW+1)'(1));
            rows_q      <= rows_c;
            cols_q      <= cols_c;
            if (line_c) begin
              first_q <= (n_c == FW'(1)) ? SG_LC : SG_LA;
            end else begin
              last_dir_q <= vert_c;
              first_q    <= rows_c[0] ? SG_O1 : SG_E1;
            end
            seg_q   <= SG_START;
            cnt_q   <= '0;
            fill_q  <= '0;
            k_q     <= '0;
            state_q <= ST_GEN;
          end
        end
        ST_GEN: begin
          if (cnt_q != '0) begin
            if (is2d_q && px_c == ax_q && py_c == ay_q) k_q <= fill_q;
            fill_q      <= fill_q + FW'(1);
            r_q         <= r_d;
            c_q         <= c_d;
            dir_q       <= dir_d;
            cnt_q       <= cnt_d;
            rows_left_q <= rows_left_d;
          end else begin
            seg_q       <= nxt_seg;
            r_q         <= ld_r;
            c_q         <= ld_c;
            dir_q       <= ld_dir;
            cnt_q       <= ld_cnt;
            rows_left_q <= ld_rows;
            if (nxt_seg == SG_DONE) state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          mod_q    <= fill_q;
          len_q    <= is2d_q ? fill_q + FW'(1) : fill_q;
          pos_q    <= '0;
          active_q <= 1'b1;
          state_q  <= ST_W1;
        end
        ST_W1: state_q <= ST_W2;
        ST_W2: state_q <= ST_LOAD;
        ST_LOAD: begin
          out_valid_q  <= 1'b1;
          out_x_q      <= rdata_q[2*CW-1:CW];
          out_y_q      <= rdata_q[CW-1:0];
          out_last_q   <= last_c;
          out_status_q <= gtpg_pkg::STATUS_OK;
          out_vert_q   <= tour_vert_q;
          pos_q        <= pos_q + FW'(1);
          if (last_c) active_q <= 1'b0;
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign req_i.ready          = (state_q == ST_IDLE) && !out_valid_q;
  assign pt_o.valid           = out_valid_q;
  assign pt_o.point_x         = out_x_q;
  assign pt_o.point_y         = out_y_q;
  assign pt_o.last_point      = out_last_q;
  assign pt_o.status          = out_status_q;
  assign pt_o.vertical_raster = out_vert_q;

  // An error result always ends the tour and carries no orientation.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_o.valid && pt_o.status != gtpg_pkg::STATUS_OK) |-> (pt_o.last_point && !pt_o.vertical_raster))
    else $error("error result without last point");

  // An active tour never reads past its stored length.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && state_q == ST_LOAD) |-> (pos_q < len_q))
    else $error("read position beyond tour length");

  // Building never writes beyond the store.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_c |-> (fill_q < FW'(DEPTH)))
    else $error("tour store overflow");

endmodule

FILE: dv/tb_grid_tour_point_generator.sv
module tb_grid_tour_point_generator;

  localparam int unsigned CW = gtpg_pkg::CoordWidthDef;
  localparam int unsigned MAXP = gtpg_pkg::MaxPointsDef;
  localparam logic [gtpg_pkg::CfgIdxW-1:0] REG_UNUSED = 4'd9;
  localparam int unsigned STALL_LIMIT = 60000;

  typedef struct {
    logic [CW-1:0]                x;
    logic [CW-1:0]                y;
    logic                         last;
    logic [gtpg_pkg::StatusW-1:0] status;
    logic                         vert;
  } tour_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gtpg_cfg_if #(.CW(CW)) cfg ();
  gtpg_req_if req ();
  gtpg_pt_if #(.CW(CW)) pt ();

  grid_tour_point_generator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req),
    .pt_o   (pt)
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the block.
  longint      bnd_xl, bnd_xh, bnd_yl, bnd_yh;
  bit          last_dir, tour_vert, tour_on, swap_xy;
  int          path_x [0:MAXP];
  int          path_y [0:MAXP];
  int unsigned path_len, rd_pos, fill;
  longint      org_x, org_y;

  tour_point_t pending_points[$];
  int          errors = 0;
  int          n_req = 0;
  bit          idling = 1'b1;

  // Random gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint anchor(longint lo, longint hi);
    if (lo > 0) return lo;
    if (hi < 0) return hi;
    return 0;
  endfunction

  function automatic void put_pt(longint row, longint col);
    if (fill > MAXP) return;
    path_x[fill] = int'(org_x + (swap_xy ? row : col));
    path_y[fill] = int'(org_y + (swap_xy ? col : row));
    fill++;
  endfunction

  function automatic void reverse_span(int unsigned lo, int unsigned hi);
    int t;
    while (lo < hi) begin
      t = path_x[lo]; path_x[lo] = path_x[hi]; path_x[hi] = t;
      t = path_y[lo]; path_y[lo] = path_y[hi]; path_y[hi] = t;
      lo++; hi--;
    end
  endfunction

  function automatic void trace_line(longint n, longint a);
    if (n == 1) begin
      put_pt(0, 0);
      return;
    end
    if (a <= n - 1 - a) begin
      for (longint c = a; c >= 0; c--) put_pt(0, c);
      for (longint c = a + 1; c < n; c++) put_pt(0, c);
    end else begin
      for (longint c = a; c < n; c++) put_pt(0, c);
      for (longint c = a - 1; c >= 0; c--) put_pt(0, c);
    end
    put_pt(0, a);
  endfunction

  function automatic void trace_even(longint rows, longint cols);
    for (longint r = 0; r < rows; r++) put_pt(r, 0);
    for (longint r = rows - 1; r >= 1; r--) begin
      if (((rows - 1 - r) & 1) == 0) begin
        for (longint c = 1; c < cols; c++) put_pt(r, c);
      end else begin
        for (longint c = cols - 1; c >= 1; c--) put_pt(r, c);
      end
    end
    for (longint c = cols - 1; c >= 1; c--) put_pt(0, c);
  endfunction

  function automatic void trace_odd(longint rows, longint cols);
    for (longint r = 0; r < rows; r++) put_pt(r, 0);
    for (longint c = 1; c < cols; c++) put_pt(rows - 1, c);
    for (longint r = rows - 2; r > 1; r--) begin
      if (((rows - 2 - r) & 1) == 0) begin
        for (longint c = cols - 1; c >= 1; c--) put_pt(r, c);
      end else begin
        for (longint c = 1; c < cols; c++) put_pt(r, c);
      end
    end
    put_pt(1, cols - 1);
    put_pt(1, cols - 2);
    put_pt(0, cols - 1);
    for (longint c = cols - 2; c >= 2; c -= 2) begin
      put_pt(0, c);
      put_pt(0, c - 1);
      put_pt(1, c - 1);
      put_pt(1, c - 2);
    end
    put_pt(0, 1);
  endfunction

  // Builds a tour from the current bounds; returns its status code.
  function automatic logic [gtpg_pkg::StatusW-1:0] build_tour();
    longint nx, ny, ax, ay;
    int unsigned grid, k;
    bit v;
    nx = (bnd_xh >= bnd_xl) ? bnd_xh - bnd_xl + 1 : 0;
    ny = (bnd_yh >= bnd_yl) ? bnd_yh - bnd_yl + 1 : 0;
    if (nx == 0 || ny == 0) return gtpg_pkg::STATUS_EMPTY;
    if (nx > MAXP || ny > MAXP || nx * ny > MAXP) return gtpg_pkg::STATUS_OVERSIZE;
    grid = int'(nx * ny);
    ax = anchor(bnd_xl, bnd_xh);
    ay = anchor(bnd_yl, bnd_yh);
    org_x = bnd_xl;
    org_y = bnd_yl;
    fill = 0;
    // Lines and single points keep the orientation history.
    if (nx == 1 || ny == 1) begin
      swap_xy = (ny != 1);
      if (swap_xy) trace_line(ny, ay - bnd_yl);
      else trace_line(nx, ax - bnd_xl);
      tour_vert = swap_xy;
      path_len = fill;
      return gtpg_pkg::STATUS_OK;
    end
    if ((nx & 1) == (ny & 1)) v = !last_dir;
    else v = ((nx & 1) == 0);
    last_dir = v;
    swap_xy = v;
    tour_vert = v;
    if (v) begin
      if ((nx & 1) == 0) trace_even(nx, ny); else trace_odd(nx, ny);
    end else begin
      if ((ny & 1) == 0) trace_even(ny, nx); else trace_odd(ny, nx);
    end
    if (fill != grid) return gtpg_pkg::STATUS_OVERSIZE;
    // Rotate so that the tour starts at the anchor, then close it.
    for (k = 0; k < grid; k++) begin
      if (path_x[k] == int'(ax) && path_y[k] == int'(ay)) break;
    end
    if (k < grid && k > 0) begin
      reverse_span(0, k - 1);
      reverse_span(k, grid - 1);
      reverse_span(0, grid - 1);
    end
    path_x[grid] = path_x[0];
    path_y[grid] = path_y[0];
    path_len = grid + 1;
    return gtpg_pkg::STATUS_OK;
  endfunction

  function automatic tour_point_t next_point(bit restart);
    tour_point_t p;
    logic [gtpg_pkg::StatusW-1:0] st;
    if (restart) tour_on = 1'b0;
    if (!tour_on) begin
      st = build_tour();
      if (st != gtpg_pkg::STATUS_OK) begin
        p.x = '0; p.y = '0; p.last = 1'b1; p.status = st; p.vert = 1'b0;
        return p;
      end
      rd_pos = 0;
      tour_on = 1'b1;
    end
    if (rd_pos >= path_len) rd_pos = 0;
    p.x = path_x[rd_pos][CW-1:0];
    p.y = path_y[rd_pos][CW-1:0];
    p.last = (rd_pos + 1 >= path_len);
    p.status = gtpg_pkg::STATUS_OK;
    p.vert = tour_vert;
    rd_pos++;
    if (p.last) tour_on = 1'b0;
    return p;
  endfunction

  // Sends one request; valid stays high after the transaction.
  task automatic send_req(bit restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.restart <= restart;
    do @(posedge clk_i); while (!req.ready);
    pending_points.push_back(next_point(restart));
    n_req++;
  endtask

  task automatic write_reg(logic [gtpg_pkg::CfgIdxW-1:0] idx, longint val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val[CW-1:0];
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      gtpg_pkg::REG_X_LOW:  bnd_xl = longint'($signed(val[CW-1:0]));
      gtpg_pkg::REG_X_HIGH: bnd_xh = longint'($signed(val[CW-1:0]));
      gtpg_pkg::REG_Y_LOW:  bnd_yl = longint'($signed(val[CW-1:0]));
      gtpg_pkg::REG_Y_HIGH: bnd_yh = longint'($signed(val[CW-1:0]));
      default: ;
    endcase
  endtask

  // Writes all bounds once every pending point has come back.
  task automatic set_grid(longint xl, longint xh, longint yl, longint yh);
    req.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(gtpg_pkg::REG_X_LOW, xl);
    write_reg(gtpg_pkg::REG_X_HIGH, xh);
    write_reg(gtpg_pkg::REG_Y_LOW, yl);
    write_reg(gtpg_pkg::REG_Y_HIGH, yh);
    cfg.valid <= 1'b0;
  endtask

  // Reads a whole tour from a fresh build.
  task automatic run_tour(longint xl, longint xh, longint yl, longint yh);
    set_grid(xl, xh, yl, yh);
    send_req(1'b1);
    while (tour_on) send_req(1'b0);
  endtask

  // Builds a large tour and reads only its first points.
  task automatic peek_tour(longint xl, longint xh, longint yl, longint yh);
    set_grid(xl, xh, yl, yh);
    send_req(1'b1);
    repeat (8) send_req(1'b0);
  endtask

  task automatic test_reset_bounds();
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b1);
  endtask

  task automatic test_directed_shapes();
    run_tour(5, 4, 0, 3);                  // empty x axis
    run_tour(0, 3, -2, -3);                // empty y axis
    run_tour(-32768, 32767, -32768, 32767); // oversize, full range
    run_tour(-32768, -32768, -32768, -32768);
    run_tour(32767, 32767, 32767, 32767);
    run_tour(-3, 6, 2, 2);                 // horizontal line, anchor inside
    run_tour(-1, -1, -9, -2);              // vertical line, anchor at high end
    run_tour(0, 1, 0, 1);
    run_tour(0, 2, 0, 2);                  // odd square twice: orientation flips
    run_tour(0, 2, 0, 2);
    run_tour(-2, 1, -1, 2);
    run_tour(1, 3, -4, -1);                // odd by even
    run_tour(-5, -2, 3, 5);                // even by odd
    run_tour(-2, 2, -2, 2);
    run_tour(0, 4096, 0, 0);               // line one beyond the point limit: oversize
    // A single stray write to an unused index must be ignored.
    req.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    write_reg(REG_UNUSED, 16'h7fff);
    cfg.valid <= 1'b0;
    send_req(1'b1);
    // Mid-tour restart after a partial read.
    set_grid(-3, 3, -2, 2);
    send_req(1'b1);
    repeat (5) send_req(1'b0);
    send_req(1'b1);
    while (tour_on) send_req(1'b0);
  endtask

  task automatic test_full_store();
    idling = 1'b0;
    peek_tour(28672, 32767, 7, 7);         // longest line at the top edge
    peek_tour(-32768, -32705, -32768, -32705); // 64 x 64
    peek_tour(-31, 33, -30, 32);           // 65 x 63
    run_tour(-32, 32, -32, 31);            // 65 x 64, oversize
    idling = 1'b1;
  endtask

  task automatic test_random_tours();
    int target, kind, cnt;
    longint nx, ny, xl, yl;
    target = n_req + 420;
    while (n_req < target) begin
      idling = ($urandom_range(0, 5) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        nx = $urandom_range(1, 14); ny = 1;
        if ($urandom_range(0, 1)) begin ny = nx; nx = 1; end
      end else begin
        nx = $urandom_range(2, 9); ny = $urandom_range(2, 9);
      end
      if ($urandom_range(0, 1)) begin
        xl = $urandom_range(0, 65535 - nx) - 32768;
        yl = $urandom_range(0, 65535 - ny) - 32768;
      end else begin
        xl = longint'($urandom_range(0, 2 * nx)) - nx;
        yl = longint'($urandom_range(0, 2 * ny)) - ny;
      end
      if (kind < 4) set_grid(xl + 3, xl, yl, yl + ny - 1);
      else if (kind < 8) set_grid(xl, xl + nx - 1, yl, yl - 1);
      else if (kind < 11) set_grid(0, 99, 0, 99);
      else set_grid(xl, xl + nx - 1, yl, yl + ny - 1);
      cnt = $urandom_range(1, int'(nx * ny) + 3);
      for (int i = 0; i < cnt; i++) send_req($urandom_range(0, 11) == 0);
    end
    idling = 1'b1;
  endtask

  // Point checker with random back-pressure.
  int stall_left = 0;
  always @(posedge clk_i) begin
    tour_point_t e;
    if (pt.valid && pt.ready) begin
      if (pending_points.size() == 0) begin
        $error("point with no request outstanding");
        errors++;
      end else begin
        e = pending_points.pop_front();
        if (pt.point_x !== e.x) begin
          $error("point_x: expected %0d, got %0d", $signed(e.x), $signed(pt.point_x));
          errors++;
        end
        if (pt.point_y !== e.y) begin
          $error("point_y: expected %0d, got %0d", $signed(e.y), $signed(pt.point_y));
          errors++;
        end
        if (pt.last_point !== e.last) begin
          $error("last_point: expected %0d, got %0d", e.last, pt.last_point);
          errors++;
        end
        if (pt.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, pt.status);
          errors++;
        end
        if (pt.vertical_raster !== e.vert) begin
          $error("vertical_raster: expected %0d, got %0d", e.vert, pt.vertical_raster);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pt.ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      pt.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (pt.valid && pt.ready) || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req.valid <= 1'b0;
    req.restart <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= gtpg_pkg::REG_X_LOW;
    cfg.data <= '0;
    bnd_xl = 0; bnd_xh = 0; bnd_yl = 0; bnd_yh = 0;
    last_dir = 1'b0; tour_vert = 1'b0; tour_on = 1'b0;
    path_len = 0; rd_pos = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_bounds();
    test_directed_shapes();
    test_full_store();
    test_random_tours();
    req.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/gtpg_pkg.sv
sv/gtpg_if.sv
sv/grid_tour_point_generator.sv
dv/tb_grid_tour_point_generator.sv
